FILE: hdl/tpi_pkg.sv
// Shared types and constants for the triangle plane slicer.
package tpi_pkg;

    localparam int DW = 50;          // signed distance width
    localparam int MW = 49;          // distance magnitude width
    localparam int QW = 16;          // weight bits, Q0.16

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_EPSILON  = 3'd4;

    localparam logic [1:0] VTX_A = 2'd0;
    localparam logic [1:0] VTX_B = 2'd1;
    localparam logic [1:0] VTX_C = 2'd2;

    typedef logic signed [31:0] t_coord;
    typedef t_coord [2:0] t_vec;
    typedef t_vec [2:0] t_tri;

    typedef struct packed {
        logic       coplanar;
        logic [1:0] cnt;
        logic [1:0] sel_a0;
        logic [1:0] sel_b0;
        logic [1:0] sel_a1;
        logic [1:0] sel_b1;
        t_tri       vtx;
    } t_side;

endpackage

FILE: hdl/triangle_plane_intersection.sv
// Pipeline: 2 distance, 1 classify, 16 divider, 2 interpolation stages.
// One item per cycle unless the output stalls; the 16-stage weight
// divider sets the depth.
// The whole pipeline advances whenever the output register is empty or taken.
// Synchronous active-low reset clears valid bits and loads the plane registers
// with their defaults (normal 0,1,0, offset 0, epsilon 1).
module triangle_plane_intersection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_cz,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_point_count,
    output logic signed [31:0] o_p0x,
    output logic signed [31:0] o_p0y,
    output logic signed [31:0] o_p0z,
    output logic signed [31:0] o_p1x,
    output logic signed [31:0] o_p1y,
    output logic signed [31:0] o_p1z,
    output logic signed [31:0] o_p2x,
    output logic signed [31:0] o_p2y,
    output logic signed [31:0] o_p2z
);

    localparam int DW = tpi_pkg::DW;
    localparam int MW = tpi_pkg::MW;

    logic                   en;
    tpi_pkg::t_coord        r_nx, r_ny, r_nz, r_off;
    logic [15:0]            r_eps;
    tpi_pkg::t_tri          in_vtx;

    logic                   d_vld;
    logic signed [DW-1:0]   d_d [3];
    tpi_pkg::t_tri          d_vtx;

    logic [MW-1:0]          n_mag [3];
    logic                   n_pos [3];
    logic                   n_neg [3];
    logic                   e01, e02, e12;
    tpi_pkg::t_side         n_side;
    logic [DW-1:0]          n_num [2];
    logic [DW-1:0]          n_den [2];

    logic                   r_cvld;
    tpi_pkg::t_side         r_side;
    logic [DW-1:0]          r_num [2];
    logic [DW-1:0]          r_den [2];

    logic                   q_vld;
    logic [tpi_pkg::QW-1:0] q_w [2];
    tpi_pkg::t_side         q_side;
    tpi_pkg::t_tri          out_pt;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    assign in_vtx[0] = '{i_az, i_ay, i_ax};
    assign in_vtx[1] = '{i_bz, i_by, i_bx};
    assign in_vtx[2] = '{i_cz, i_cy, i_cx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx  <= 32'sd0;
            r_ny  <= 32'sd65536;
            r_nz  <= 32'sd0;
            r_off <= 32'sd0;
            r_eps <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpi_pkg::REG_NORMAL_X: r_nx  <= i_cfg_data;
                tpi_pkg::REG_NORMAL_Y: r_ny  <= i_cfg_data;
                tpi_pkg::REG_NORMAL_Z: r_nz  <= i_cfg_data;
                tpi_pkg::REG_OFFSET:   r_off <= i_cfg_data;
                tpi_pkg::REG_EPSILON:  r_eps <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tpi_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_vtx   (in_vtx),
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .i_nz    (r_nz),
        .i_off   (r_off),
        .o_vld   (d_vld),
        .o_d     (d_d),
        .o_vtx   (d_vtx)
    );

    // Classify vertices and choose the split edges in ab, ac, bc order.
    always_comb begin
        logic [DW-1:0] m;
        for (int i = 0; i < 3; i++) begin
            m        = d_d[i][DW-1] ? DW'(-d_d[i]) : DW'(d_d[i]);
            n_mag[i] = m[MW-1:0];
            n_neg[i] = d_d[i][DW-1];
            n_pos[i] = !d_d[i][DW-1] && (d_d[i] != '0);
        end
        e01 = (n_pos[0] && n_neg[1]) || (n_neg[0] && n_pos[1]);
        e02 = (n_pos[0] && n_neg[2]) || (n_neg[0] && n_pos[2]);
        e12 = (n_pos[1] && n_neg[2]) || (n_neg[1] && n_pos[2]);

        n_side.vtx      = d_vtx;
        n_side.coplanar = (n_mag[0] < MW'(r_eps)) && (n_mag[1] < MW'(r_eps))
                       && (n_mag[2] < MW'(r_eps));
        n_side.cnt      = 2'(e01) + 2'(e02) + 2'(e12);
        if (n_side.cnt == 2'd3) n_side.cnt = 2'd2;
        n_side.sel_a0   = e01 ? tpi_pkg::VTX_A : (e02 ? tpi_pkg::VTX_A : tpi_pkg::VTX_B);
        n_side.sel_b0   = e01 ? tpi_pkg::VTX_B : tpi_pkg::VTX_C;
        n_side.sel_a1   = (e01 && e02) ? tpi_pkg::VTX_A : tpi_pkg::VTX_B;
        n_side.sel_b1   = tpi_pkg::VTX_C;

        n_num[0] = {1'b0, e01 ? n_mag[1] : n_mag[2]};
        n_den[0] = {1'b0, e01 ? n_mag[0] : (e02 ? n_mag[0] : n_mag[1])} + n_num[0];
        n_num[1] = {1'b0, n_mag[2]};
        n_den[1] = {1'b0, (e01 && e02) ? n_mag[0] : n_mag[1]} + n_num[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
        end else if (en) begin
            r_cvld <= d_vld;
        end
        if (en) begin
            r_side <= n_side;
            r_num  <= n_num;
            r_den  <= n_den;
        end
    end

    tpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_cvld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side),
        .o_vld   (q_vld),
        .o_q     (q_w),
        .o_side  (q_side)
    );

    tpi_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_w     (q_w),
        .i_side  (q_side),
        .o_vld   (o_valid),
        .o_cnt   (o_point_count),
        .o_pt    (out_pt)
    );

    assign o_p0x = out_pt[0][0];
    assign o_p0y = out_pt[0][1];
    assign o_p0z = out_pt[0][2];
    assign o_p1x = out_pt[1][0];
    assign o_p1y = out_pt[1][1];
    assign o_p1z = out_pt[1][2];
    assign o_p2x = out_pt[2][0];
    assign o_p2y = out_pt[2][1];
    assign o_p2z = out_pt[2][2];

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid) else $error("output valid after reset");
    a_slot2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_count != 2'd3 |-> o_p2x == 0 && o_p2y == 0 && o_p2z == 0)
        else $error("third point set without coplanar result");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_count == 2'd0 |-> o_p0x == 0 && o_p1x == 0)
        else $error("points set with zero count");
`endif

endmodule

FILE: hdl/tpi_dist.sv
// Signed plane distance of the three vertices: products, then sum.
module tpi_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  tpi_pkg::t_tri                   i_vtx,
    input  tpi_pkg::t_coord                 i_nx,
    input  tpi_pkg::t_coord                 i_ny,
    input  tpi_pkg::t_coord                 i_nz,
    input  tpi_pkg::t_coord                 i_off,
    output logic                            o_vld,
    output logic signed [tpi_pkg::DW-1:0]   o_d [3],
    output tpi_pkg::t_tri                   o_vtx
);

    logic                  r_vld1;
    logic signed [47:0]    r_t [3][3];
    tpi_pkg::t_tri         r_vtx1;
    logic signed [63:0]    n_p [3][3];
    logic                  r_vld2;
    logic signed [tpi_pkg::DW-1:0] r_d [3];
    tpi_pkg::t_tri         r_vtx2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p[i][0] = i_nx * i_vtx[i][0];
            n_p[i][1] = i_ny * i_vtx[i][1];
            n_p[i][2] = i_nz * i_vtx[i][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                // Arithmetic shift floors the Q32.32 product to Q32.16.
                for (int k = 0; k < 3; k++) r_t[i][k] <= n_p[i][k][63:16];
                r_d[i] <= tpi_pkg::DW'(r_t[i][0]) + tpi_pkg::DW'(r_t[i][1])
                        + tpi_pkg::DW'(r_t[i][2]) + tpi_pkg::DW'(i_off);
            end
            r_vtx1 <= i_vtx;
            r_vtx2 <= r_vtx1;
        end
    end

    assign o_vld = r_vld2;
    assign o_d   = r_d;
    assign o_vtx = r_vtx2;

endmodule

FILE: hdl/tpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module tpi_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [tpi_pkg::DW-1:0]          i_num [2],
    input  logic [tpi_pkg::DW-1:0]          i_den [2],
    input  tpi_pkg::t_side                  i_side,
    output logic                            o_vld,
    output logic [tpi_pkg::QW-1:0]          o_q [2],
    output tpi_pkg::t_side                  o_side
);

    localparam int NS = tpi_pkg::QW;

    logic                          r_vld  [NS];
    logic [tpi_pkg::DW-1:0]        r_rem  [NS][2];
    logic [tpi_pkg::DW-1:0]        r_den  [NS][2];
    logic [tpi_pkg::QW-1:0]        r_q    [NS][2];
    tpi_pkg::t_side                r_side [NS];

    logic [tpi_pkg::DW-1:0]        n_rem  [NS][2];
    logic                          n_bit  [NS][2];

    always_comb begin
        logic [tpi_pkg::DW:0] sh;
        logic [tpi_pkg::DW-1:0] rin;
        logic [tpi_pkg::DW-1:0] din;
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < 2; l++) begin
                rin = (s == 0) ? i_num[l] : r_rem[(s == 0) ? 0 : s - 1][l];
                din = (s == 0) ? i_den[l] : r_den[(s == 0) ? 0 : s - 1][l];
                sh  = {rin, 1'b0};
                n_bit[s][l] = (sh >= {1'b0, din});
                n_rem[s][l] = n_bit[s][l] ? tpi_pkg::DW'(sh - {1'b0, din})
                                          : sh[tpi_pkg::DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NS; s++) r_vld[s] <= r_vld[s-1];
        end
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    if (s == 0) begin
                        r_den[s][l] <= i_den[l];
                        r_q[s][l]   <= {{(tpi_pkg::QW-1){1'b0}}, n_bit[s][l]};
                    end else begin
                        r_den[s][l] <= r_den[s-1][l];
                        r_q[s][l]   <= {r_q[s-1][l][tpi_pkg::QW-2:0], n_bit[s][l]};
                    end
                end
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_q    = r_q[NS-1];
    assign o_side = r_side[NS-1];

endmodule

FILE: hdl/tpi_lerp.sv
// Edge interpolation with the weights and final selection of result points.
module tpi_lerp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [tpi_pkg::QW-1:0]      i_w [2],
    input  tpi_pkg::t_side              i_side,
    output logic                        o_vld,
    output logic [1:0]                  o_cnt,
    output tpi_pkg::t_tri               o_pt
);

    logic                  r_vld1;
    logic signed [50:0]    r_pa [2][3];
    logic signed [50:0]    r_pb [2][3];
    tpi_pkg::t_side        r_side;
    logic                  r_vld2;
    logic [1:0]            r_cnt;
    tpi_pkg::t_tri         r_pt;

    tpi_pkg::t_vec         n_va [2];
    tpi_pkg::t_vec         n_vb [2];
    logic [16:0]           n_wa [2];
    logic [16:0]           n_wb [2];
    logic signed [51:0]    n_sum;
    tpi_pkg::t_tri         n_pt;

    function automatic tpi_pkg::t_vec pick(input tpi_pkg::t_tri v, input logic [1:0] s);
        tpi_pkg::t_vec r;
        case (s)
            tpi_pkg::VTX_A: r = v[0];
            tpi_pkg::VTX_B: r = v[1];
            default:        r = v[2];
        endcase
        return r;
    endfunction

    always_comb begin
        n_va[0] = pick(i_side.vtx, i_side.sel_a0);
        n_vb[0] = pick(i_side.vtx, i_side.sel_b0);
        n_va[1] = pick(i_side.vtx, i_side.sel_a1);
        n_vb[1] = pick(i_side.vtx, i_side.sel_b1);
        for (int l = 0; l < 2; l++) begin
            n_wa[l] = {1'b0, i_w[l]};
            n_wb[l] = 17'd65536 - n_wa[l];
        end
    end

    always_comb begin
        n_sum = '0;
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                if (p < 2) n_sum = 52'(r_pa[p][k]) + 52'(r_pb[p][k]);
                else       n_sum = '0;
                if (r_side.coplanar)
                    n_pt[p][k] = r_side.vtx[p][k];
                else if (p < 2 && r_side.cnt > 2'(p))
                    n_pt[p][k] = n_sum[47:16];
                else
                    n_pt[p][k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pa[l][k] <= $signed({n_va[l][k][31], n_va[l][k]})
                                * $signed({1'b0, n_wa[l]});
                    r_pb[l][k] <= $signed({n_vb[l][k][31], n_vb[l][k]})
                                * $signed({1'b0, n_wb[l]});
                end
            end
            r_side <= i_side;
            r_cnt  <= r_side.coplanar ? 2'd3 : r_side.cnt;
            r_pt   <= n_pt;
        end
    end

    assign o_vld = r_vld2;
    assign o_cnt = r_cnt;
    assign o_pt  = r_pt;

endmodule
